// File: design/rcp_pkg.sv
// Shared types and constants for the run-length cell pattern decoder.
package rcp_pkg;

  localparam int MAX_SIDE_DEF   = 4096;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CHAR_W   = 8;
  localparam int GRID_W   = 13;
  localparam int POS_W    = 12;
  localparam int LEN_W    = 13;
  localparam int CURSOR_W = 16;
  localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [GRID_W-1:0]    GRID_RESET      = 13'd64;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_END   = 8'h21; // '!'
  localparam logic [CHAR_W-1:0] CH_DEAD  = 8'h62; // 'b'
  localparam logic [CHAR_W-1:0] CH_LIVE  = 8'h6f; // 'o'
  localparam logic [CHAR_W-1:0] CH_ROW   = 8'h24; // '$'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39; // '9'
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;

  localparam int DIGIT_W = 4;
  localparam int TEN_X3  = 3; // *10 = (x << 3) + (x << 1)
  localparam int TEN_X1  = 1;

  localparam int CMD_W = 2;
  typedef enum logic [CMD_W-1:0] {
    CMD_COL  = 2'd0,
    CMD_ROW  = 2'd1,
    CMD_SPAN = 2'd2,
    CMD_END  = 2'd3
  } cmd_op_t;

  localparam logic RES_SPAN = 1'b0;
  localparam logic RES_END  = 1'b1;

endpackage

// File: design/rcp_if.sv
// Valid/ready channel interfaces for byte input and span results.
interface rcp_in_if import rcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface rcp_out_if import rcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [POS_W-1:0] span_row;
  logic [POS_W-1:0] span_col;
  logic [LEN_W-1:0] span_len;

  modport source (output valid, output result_kind, output span_row,
                  output span_col, output span_len, input ready);
  modport sink   (input valid, input result_kind, input span_row,
                  input span_col, input span_len, output ready);
endinterface

// File: design/rcp_front.sv
// Front end: classifies bytes, builds the run count, issues commands.
module rcp_front import rcp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  logic [CHAR_W-1:0]     byte_in,
  input  logic                  q_full,
  output logic                  byte_ready,
  output logic                  cmd_push,
  output cmd_op_t               cmd_op,
  output logic [COUNT_BITS-1:0] cmd_count
);

  localparam int MUL_W = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] run_accum_r, run_accum_nxt;
  logic                  finished_r, finished_nxt;
  logic                  accept, is_digit, is_blank;
  logic [MUL_W-1:0]      prod;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign is_digit   = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign is_blank   = (byte_in == CH_SPACE) || (byte_in == CH_TAB) ||
                      (byte_in == CH_CR) || (byte_in == CH_LF);
  assign prod       = (MUL_W'(run_accum_r) << TEN_X3) + (MUL_W'(run_accum_r) << TEN_X1)
                      + MUL_W'(byte_in[DIGIT_W-1:0]);
  assign cmd_count  = (run_accum_r == '0) ? COUNT_BITS'(1) : run_accum_r;

  always_comb begin
    run_accum_nxt = run_accum_r;
    finished_nxt  = finished_r;
    cmd_push      = 1'b0;
    cmd_op        = CMD_END;
    if (accept && !finished_r) begin
      if (byte_in == CH_END) begin
        finished_nxt = 1'b1;
        cmd_push     = 1'b1;
        cmd_op       = CMD_END;
      end else if (is_blank) begin
        run_accum_nxt = run_accum_r;
      end else if (is_digit) begin
        run_accum_nxt = (prod > MUL_W'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_BITS-1:0];
      end else begin
        run_accum_nxt = '0;
        case (byte_in)
          CH_DEAD: begin
            cmd_push = 1'b1;
            cmd_op   = CMD_COL;
          end
          CH_ROW: begin
            cmd_push = 1'b1;
            cmd_op   = CMD_ROW;
          end
          CH_LIVE: begin
            cmd_push = 1'b1;
            cmd_op   = CMD_SPAN;
          end
          default: begin
            cmd_push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_accum_r <= '0;
      finished_r  <= 1'b0;
    end else begin
      run_accum_r <= run_accum_nxt;
      finished_r  <= finished_nxt;
    end
  end

endmodule

// File: design/rcp_queue.sv
// Short command queue between front and back.
module rcp_queue import rcp_pkg::*; #(
  parameter int DATA_W = CMD_W + COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output logic [DATA_W-1:0] head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/rcp_back.sv
// Back end: cursor update, span clipping and the result register.
module rcp_back import rcp_pkg::*; #(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  cmd_op_t               cmd_op,
  input  logic [COUNT_BITS-1:0] cmd_count,
  output logic                  cmd_pop,
  input  logic [GRID_W-1:0]     grid_width,
  input  logic [GRID_W-1:0]     grid_height,
  input  logic                  res_ready,
  output logic                  res_valid,
  output logic                  res_kind,
  output logic [POS_W-1:0]      res_row,
  output logic [POS_W-1:0]      res_col,
  output logic [LEN_W-1:0]      res_len
);

  localparam int SUM_W = ((COUNT_BITS > CURSOR_W) ? COUNT_BITS : CURSOR_W) + 1;
  localparam int CMP_W = 32;

  logic [CURSOR_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic                valid_r, valid_nxt;
  logic                kind_r, kind_nxt;
  logic [POS_W-1:0]    orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [LEN_W-1:0]    olen_r, olen_nxt;
  logic                slot_free, in_grid;
  logic [GRID_W-1:0]   w_eff, h_eff, room;
  logic [CURSOR_W-1:0] col_adv, row_adv;
  logic [LEN_W-1:0]    clip_len;

  function automatic logic [CURSOR_W-1:0] sat_add(input logic [CURSOR_W-1:0] base,
                                                 input logic [COUNT_BITS-1:0] amt);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(amt);
    return (s > SUM_W'(CURSOR_MAX)) ? CURSOR_MAX : s[CURSOR_W-1:0];
  endfunction

  assign w_eff = (CMP_W'(grid_width) > CMP_W'(MAX_SIDE)) ? GRID_W'(MAX_SIDE) : grid_width;
  assign h_eff = (CMP_W'(grid_height) > CMP_W'(MAX_SIDE)) ? GRID_W'(MAX_SIDE) : grid_height;

  assign in_grid  = (row_r < CURSOR_W'(h_eff)) && (col_r < CURSOR_W'(w_eff));
  assign room     = w_eff - col_r[GRID_W-1:0];
  assign clip_len = (SUM_W'(cmd_count) < SUM_W'(room)) ? LEN_W'(cmd_count) : LEN_W'(room);
  assign col_adv  = sat_add(col_r, cmd_count);
  assign row_adv  = sat_add(row_r, cmd_count);

  assign slot_free = !valid_r || res_ready;
  assign cmd_pop   = cmd_valid && slot_free;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    valid_nxt = valid_r && !res_ready;
    kind_nxt  = kind_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    olen_nxt  = olen_r;
    if (cmd_pop) begin
      case (cmd_op)
        CMD_COL: begin
          col_nxt = col_adv;
        end
        CMD_ROW: begin
          row_nxt = row_adv;
          col_nxt = '0;
        end
        CMD_SPAN: begin
          col_nxt = col_adv;
          if (in_grid) begin
            valid_nxt = 1'b1;
            kind_nxt  = RES_SPAN;
            orow_nxt  = row_r[POS_W-1:0];
            ocol_nxt  = col_r[POS_W-1:0];
            olen_nxt  = clip_len;
          end
        end
        CMD_END: begin
          valid_nxt = 1'b1;
          kind_nxt  = RES_END;
          orow_nxt  = '0;
          ocol_nxt  = '0;
          olen_nxt  = '0;
        end
        default: begin
          col_nxt = col_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    olen_r <= olen_nxt;
  end

  assign res_valid = valid_r;
  assign res_kind  = kind_r;
  assign res_row   = orow_r;
  assign res_col   = ocol_r;
  assign res_len   = olen_r;

endmodule

// File: design/rle_cell_pattern_decoder.sv
// Top level of the run-length cell pattern decoder.
//
//  channel  | dir | beat contents                          | handshake
//  ---------+-----+----------------------------------------+-------------
//  in_ch    | in  | char_byte                              | valid/ready
//  out_ch   | out | result_kind, span_row, span_col, len   | valid/ready
//  cfg_*    | in  | cfg_index, cfg_data                    | cfg_we only
//
// One byte per cycle while the queue is not full. The front classifies and
// counts a byte as it arrives and queues its command as it takes the byte; the
// back moves it into the result register when free, and offers a beat there.
// Reset is synchronous on rst_n low; clears count, cursors, end flag, queue.
// A stalled out_ch holds the back; the two-entry command queue keeps in_ch
// open until it fills, so in_ready drops only when the queue is full.
module rle_cell_pattern_decoder import rcp_pkg::*; #(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rcp_in_if.sink               in_ch,
  rcp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GRID_W-1:0]    cfg_data
);

  localparam int Q_W = CMD_W + COUNT_BITS;

  // Grid size registers
  logic [GRID_W-1:0] grid_width_r, grid_width_nxt;
  logic [GRID_W-1:0] grid_height_r, grid_height_nxt;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_nxt  = cfg_data;
        CFG_GRID_HEIGHT: grid_height_nxt = cfg_data;
        default: begin
          grid_width_nxt = grid_width_r; // unknown index: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  // Front -> queue -> back
  logic                  cmd_push, cmd_pop, q_full, q_valid;
  cmd_op_t               push_op;
  logic [COUNT_BITS-1:0] push_count;
  logic [Q_W-1:0]        head_data;

  rcp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_in    (in_ch.char_byte),
    .q_full     (q_full),
    .byte_ready (in_ch.ready),
    .cmd_push   (cmd_push),
    .cmd_op     (push_op),
    .cmd_count  (push_count)
  );

  rcp_queue #(.DATA_W(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data ({push_op, push_count}),
    .pop       (cmd_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_data (head_data)
  );

  rcp_back #(.MAX_SIDE(MAX_SIDE), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_valid),
    .cmd_op      (cmd_op_t'(head_data[Q_W-1 -: CMD_W])),
    .cmd_count   (head_data[COUNT_BITS-1:0]),
    .cmd_pop     (cmd_pop),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .res_ready   (out_ch.ready),
    .res_valid   (out_ch.valid),
    .res_kind    (out_ch.result_kind),
    .res_row     (out_ch.span_row),
    .res_col     (out_ch.span_col),
    .res_len     (out_ch.span_len)
  );

endmodule
